### rtl/fca_pkg.sv
// Shared types and constants for the FAT12 cluster chain allocator.
package fca_pkg;

	localparam int ENTRY_W = 12;
	localparam int SIZE_W  = 22;

	localparam logic [ENTRY_W-1:0] END_OF_CHAIN       = 12'hFFF;
	localparam logic [ENTRY_W-1:0] LAST_CLUSTER_RESET = 12'd2848;
	localparam logic [ENTRY_W-1:0] FIRST_CLUSTER      = 12'd2;
	localparam logic [SIZE_W-1:0]  FREE_BYTES_MAX     = 22'h3FFFFF;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_ALLOC = 2'd2,
		MODE_NOP   = 2'd3
	} fca_mode_t;

	typedef struct packed {
		fca_mode_t          mode;
		logic [ENTRY_W-1:0] entry_index;
		logic [ENTRY_W-1:0] entry_value;
		logic [SIZE_W-1:0]  file_size;
	} fca_req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] read_value;
		logic [ENTRY_W-1:0] first_cluster;
		logic [SIZE_W-1:0]  free_bytes;
		logic               status;
	} fca_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;
		logic capture;
		logic wr_entry;
		logic rd_entry;
		logic issue_cnt;
		logic calc_bytes;
		logic init_alloc;
		logic issue_alloc;
		logic wr_eoc;
		logic load_rsp;
	} fca_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic      clear_last;
		fca_mode_t mode;
		logic      top_reached;
		logic      need_alloc;
		logic      alloc_done;
	} fca_stat_t;

endpackage

### rtl/fca_ctrl.sv
// Sequencer for the FAT12 allocator: clear sweep, entry access, count and allocate scans.
module fca_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  fca_pkg::fca_mode_t  req_mode,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  fca_pkg::fca_stat_t  stat,
	output fca_pkg::fca_cmd_t   cmd
);
	import fca_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_CNT,
		S_MUL,
		S_TEST,
		S_ALLOC,
		S_EOC,
		S_DONE
	} state_t;

	state_t state_q, state_nx;
	logic   rsp_valid_q;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					unique case (req_mode)
						MODE_WRITE, MODE_READ: state_nx = S_EXEC;
						MODE_ALLOC:            state_nx = S_CNT;
						default:               state_nx = S_DONE;
					endcase
				end
			end
			S_EXEC: begin
				cmd.wr_entry = (stat.mode == MODE_WRITE);
				cmd.rd_entry = (stat.mode == MODE_READ);
				state_nx     = S_DONE;
			end
			S_CNT: begin
				cmd.issue_cnt = !stat.top_reached;
				if (stat.top_reached) begin
					state_nx = S_MUL;
				end
			end
			S_MUL: begin
				cmd.calc_bytes = 1'b1;
				state_nx       = S_TEST;
			end
			S_TEST: begin
				if (stat.need_alloc) begin
					cmd.init_alloc = 1'b1;
					state_nx       = S_ALLOC;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_ALLOC: begin
				if (stat.alloc_done) begin
					state_nx = S_EOC;
				end else begin
					cmd.issue_alloc = !stat.top_reached;
				end
			end
			S_EOC: begin
				cmd.wr_eoc = 1'b1;
				state_nx   = S_DONE;
			end
			S_DONE: begin
				// result register must be free or draining this cycle
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.load_rsp = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/fca_dp.sv
// Datapath for the FAT12 allocator: table memory, scan counter, free count and chain linking.
module fca_dp #(
	parameter int FAT_ENTRIES   = 4096,
	parameter int CLUSTER_BYTES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [fca_pkg::ENTRY_W-1:0]   cfg_wr_data,
	input  fca_pkg::fca_req_t             req,
	input  fca_pkg::fca_cmd_t             cmd,
	output fca_pkg::fca_stat_t            stat,
	output fca_pkg::fca_rsp_t             rsp
);
	import fca_pkg::*;

	localparam int ADR_W   = $clog2(FAT_ENTRIES);
	localparam int CNT_W   = ADR_W;
	localparam int CB_W    = $clog2(CLUSTER_BYTES + 1);
	localparam int BYTES_W = CNT_W + CB_W;
	localparam int CMP_W   = ((BYTES_W > SIZE_W) ? BYTES_W : SIZE_W) + 2;
	localparam int CTR_W   = ENTRY_W + 1;

	localparam logic [CTR_W-1:0] ENTRIES_C = CTR_W'(FAT_ENTRIES);
	localparam logic [CTR_W-1:0] TOP_MAX_C = CTR_W'(FAT_ENTRIES - 1);
	localparam logic [CMP_W-1:0] CB_C      = CMP_W'(CLUSTER_BYTES);

	// table storage
	logic [ENTRY_W-1:0] fat_mem [FAT_ENTRIES];

	logic [ENTRY_W-1:0] last_q;
	fca_req_t           req_q;
	logic [CTR_W-1:0]   addr_q;
	logic               cnt_s1, alc_s1;
	logic [ENTRY_W-1:0] rdata_s1;
	logic [ADR_W-1:0]   raddr_s1;
	logic [CNT_W-1:0]   free_cnt_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [CMP_W-1:0]   taken_q;
	logic [ADR_W-1:0]   prev_q;
	logic               has_prev_q;
	logic [ENTRY_W-1:0] head_q;
	logic               done_q;
	fca_rsp_t           rsp_q;

	logic [CTR_W-1:0]   last_ext, top_c;
	logic               idx_ok, take;
	logic [CMP_W-1:0]   size_ext, bytes_ext, taken_nx;
	logic [SIZE_W-1:0]  free_sat;
	logic               wr_en, rd_en;
	logic [ADR_W-1:0]   wr_addr, rd_addr;
	logic [ENTRY_W-1:0] wr_data;
	fca_rsp_t           rsp_nx;

	// scan range and space test
	always_comb begin
		last_ext  = {1'b0, last_q};
		top_c     = (last_ext > TOP_MAX_C) ? TOP_MAX_C : last_ext;
		idx_ok    = ({1'b0, req_q.entry_index} < ENTRIES_C);
		size_ext  = CMP_W'(req_q.file_size);
		bytes_ext = CMP_W'(bytes_q);
		taken_nx  = taken_q + CB_C;
		take      = alc_s1 && (rdata_s1 == '0) && !done_q;
		free_sat  = (bytes_ext > CMP_W'(FREE_BYTES_MAX)) ? FREE_BYTES_MAX
			: bytes_ext[SIZE_W-1:0];
	end

	assign stat.clear_last  = (addr_q == TOP_MAX_C);
	assign stat.mode        = req_q.mode;
	assign stat.top_reached = (addr_q > top_c);
	assign stat.need_alloc  = (req_q.file_size != '0) && (size_ext <= bytes_ext);
	assign stat.alloc_done  = done_q;

	// memory port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q[ADR_W-1:0];
		wr_data = '0;
		if (cmd.clear) begin
			wr_en = 1'b1;
		end else if (cmd.wr_entry) begin
			wr_en   = idx_ok;
			wr_addr = req_q.entry_index[ADR_W-1:0];
			wr_data = req_q.entry_value;
		end else if (cmd.wr_eoc) begin
			wr_en   = 1'b1;
			wr_addr = prev_q;
			wr_data = END_OF_CHAIN;
		end else if (take && has_prev_q) begin
			// link the previous cluster to the one just found
			wr_en   = 1'b1;
			wr_addr = prev_q;
			wr_data = ENTRY_W'(raddr_s1);
		end
		rd_en   = (cmd.rd_entry && idx_ok) || cmd.issue_cnt || cmd.issue_alloc;
		rd_addr = cmd.rd_entry ? req_q.entry_index[ADR_W-1:0] : addr_q[ADR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fat_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= fat_mem[rd_addr];
			raddr_s1 <= rd_addr;
		end
	end

	// request word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	// scan and allocation control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= LAST_CLUSTER_RESET;
			addr_q     <= '0;
			cnt_s1     <= 1'b0;
			alc_s1     <= 1'b0;
			free_cnt_q <= '0;
			bytes_q    <= '0;
			taken_q    <= '0;
			prev_q     <= '0;
			has_prev_q <= 1'b0;
			head_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				last_q <= cfg_wr_data;
			end
			if (cmd.clear || cmd.issue_cnt || cmd.issue_alloc) begin
				addr_q <= addr_q + CTR_W'(1);
			end else if (cmd.capture || cmd.init_alloc) begin
				addr_q <= CTR_W'(FIRST_CLUSTER);
			end
			cnt_s1 <= cmd.issue_cnt;
			alc_s1 <= cmd.issue_alloc;
			if (cmd.capture) begin
				free_cnt_q <= '0;
				head_q     <= '0;
			end else begin
				if (cnt_s1 && (rdata_s1 == '0)) begin
					free_cnt_q <= free_cnt_q + CNT_W'(1);
				end
				if (take && !has_prev_q) begin
					head_q <= ENTRY_W'(raddr_s1);
				end
			end
			if (cmd.calc_bytes) begin
				bytes_q <= BYTES_W'(free_cnt_q) * BYTES_W'(CLUSTER_BYTES);
			end
			if (cmd.init_alloc) begin
				taken_q    <= '0;
				has_prev_q <= 1'b0;
				done_q     <= 1'b0;
			end else if (take) begin
				taken_q    <= taken_nx;
				prev_q     <= raddr_s1;
				has_prev_q <= 1'b1;
				if (taken_nx >= size_ext) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// result word
	always_comb begin
		rsp_nx = '0;
		case (req_q.mode)
			MODE_READ: begin
				rsp_nx.read_value = idx_ok ? rdata_s1 : '0;
			end
			MODE_ALLOC: begin
				rsp_nx.first_cluster = head_q;
				rsp_nx.free_bytes    = free_sat;
				rsp_nx.status        = (size_ext > bytes_ext);
			end
			default: rsp_nx = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rsp) begin
			rsp_q <= rsp_nx;
		end
	end

	assign rsp = rsp_q;

endmodule

### rtl/fat12_cluster_chain_allocator_core.sv
// Top level of the FAT12 cluster chain allocator.
// Holds a FAT12 table of FAT_ENTRIES unpacked 12-bit entries in one memory with one write
// and one read port. After reset the block sweeps the table to zero, one entry per cycle,
// with req_stall high; the last_cluster register can be written during the sweep. One
// request word is worked at a time. A write or read passes through an execute state and
// then a done state that loads the result; the unused mode goes straight to the done
// state. An allocation scans clusters 2 up to min(last_cluster, FAT_ENTRIES-1) once to
// count free entries, one memory read per cycle, then scans again from cluster 2 until
// enough clusters are linked and writes the end-of-chain mark. A failed or zero-size
// allocation skips the second scan. The result sits in an output register, so the next
// request can be accepted while a result is still stalled; a further result then waits.
module fat12_cluster_chain_allocator_core #(
	parameter int FAT_ENTRIES   = 4096,
	parameter int CLUSTER_BYTES = 512
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [fca_pkg::ENTRY_W-1:0]  cfg_wr_data,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  fca_pkg::fca_req_t            req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output fca_pkg::fca_rsp_t            rsp
);
	import fca_pkg::*;

	fca_cmd_t  cmd;
	fca_stat_t stat;

	fca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_mode  (req.mode),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	fca_dp #(
		.FAT_ENTRIES   (FAT_ENTRIES),
		.CLUSTER_BYTES (CLUSTER_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.cmd         (cmd),
		.stat        (stat),
		.rsp         (rsp)
	);

endmodule

### rtl/fca_chk.sv
// Port-level checks for the FAT12 allocator, bound to the top level.
module fca_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input fca_pkg::fca_rsp_t  rsp
);
	import fca_pkg::*;

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	// one request in flight: busy right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while previous one in work");

	// a failed allocation reports no chain
	a_fail_no_chain: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> (rsp.first_cluster == '0) && (rsp.read_value == '0))
		else $error("no-space result carries a chain head or read data");

	// read data excludes allocation fields
	a_read_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.read_value != '0) |->
			(rsp.first_cluster == '0) && (rsp.free_bytes == '0))
		else $error("read result mixed with allocation fields");

	// a chain head is a data cluster
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.first_cluster != '0) |->
			(rsp.first_cluster >= FIRST_CLUSTER) && !rsp.status)
		else $error("chain head below first data cluster");

endmodule

bind fat12_cluster_chain_allocator_core fca_chk u_fca_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
